FILE: sv/resource_reservation_scheduler_defines.svh
// Assertion macros for the reservation scheduler.
`ifndef RESOURCE_RESERVATION_SCHEDULER_DEFINES_SVH
`define RESOURCE_RESERVATION_SCHEDULER_DEFINES_SVH
`ifndef ASSERT_OFF
`define RRS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("%m");
`define RRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("%m");
`else
`define RRS_ASSERT(label, clk, rst_n, prop)
`define RRS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/rrs_pkg.sv
// Shared types and codes of the reservation scheduler.
package rrs_pkg;
  localparam int unsigned MAX_CHANNELS = 8;
  localparam int unsigned MAX_SLOTS = 16;

  localparam logic [1:0] CMD_RESERVE  = 2'd0;
  localparam logic [1:0] CMD_CANCEL   = 2'd1;
  localparam logic [1:0] CMD_COMPLETE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_REGRESS   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_STALE     = 3'd4;
  localparam logic [2:0] ST_NOT_READY = 3'd5;
  localparam logic [2:0] ST_BAD_ARG   = 3'd6;

  localparam logic [1:0] DISP_SETTLED   = 2'd0;
  localparam logic [1:0] DISP_CANCELLED = 2'd1;
  localparam logic [1:0] DISP_DEFERRED  = 2'd2;
  localparam logic [1:0] DISP_RETAINED  = 2'd3;

  localparam logic [1:0] REG_PIPE  = 2'd0;
  localparam logic [1:0] REG_II    = 2'd1;
  localparam logic [1:0] REG_CHANS = 2'd2;
  localparam logic [1:0] REG_SLOTS = 2'd3;

  localparam int unsigned GEN_BITS = 32;
  localparam int unsigned OWNER_BITS = 32;

  typedef struct packed {
    logic load;
    logic scan_slot;
    logic scan_chan;
    logic calc;
    logic commit;
  } rrs_cmd_t;

  typedef struct packed {
    logic slot_done;
    logic chan_done;
  } rrs_stat_t;
endpackage

FILE: sv/rrs_ctrl.sv
// Sequencing controller of the reservation scheduler.
module rrs_ctrl import rrs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic      is_reserve_i,
  input  rrs_stat_t stat_i,
  output rrs_cmd_t  cmd_o,
  output logic      busy
);
  typedef enum logic [2:0] {
    S_IDLE, S_SLOT, S_CHAN, S_CALC, S_COMMIT, S_RESP
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: if (start) state_q <= is_reserve_i ? S_SLOT : S_COMMIT;
        S_SLOT: if (stat_i.slot_done) state_q <= S_CHAN;
        S_CHAN: if (stat_i.chan_done) state_q <= S_CALC;
        S_CALC: state_q <= S_COMMIT;
        S_COMMIT: state_q <= S_RESP;
        S_RESP: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.load = (state_q == S_IDLE) && start;
    cmd_o.scan_slot = (state_q == S_SLOT);
    cmd_o.scan_chan = (state_q == S_CHAN);
    cmd_o.calc = (state_q == S_CALC);
    cmd_o.commit = (state_q == S_COMMIT);
  end

  assign busy = (state_q != S_IDLE);
endmodule

FILE: sv/rrs_datapath.sv
// Tables, scans and time arithmetic of the reservation scheduler.
`include "resource_reservation_scheduler_defines.svh"
module rrs_datapath import rrs_pkg::*; #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rrs_cmd_t              cmd_i,
  output rrs_stat_t             stat_o,
  output logic                  is_reserve_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [31:0]           cfg_data_i,
  input  logic [1:0]            command_i,
  input  logic [TIME_BITS-1:0]  now_time_i,
  input  logic [TIME_BITS-1:0]  earliest_i,
  input  logic [TIME_BITS-1:0]  duration_i,
  input  logic [OWNER_BITS-1:0] owner_id_i,
  input  logic [3:0]            ticket_slot_i,
  input  logic [GEN_BITS-1:0]   ticket_generation_i,
  input  logic [TIME_BITS-1:0]  at_time_i,
  output logic                  done_o,
  output logic [2:0]            status_o,
  output logic [TIME_BITS-1:0]  start_time_o,
  output logic [TIME_BITS-1:0]  finish_time_o,
  output logic [TIME_BITS-1:0]  wait_time_o,
  output logic [3:0]            granted_slot_o,
  output logic [2:0]            granted_channel_o,
  output logic [GEN_BITS-1:0]   granted_generation_o,
  output logic [1:0]            disposition_o,
  output logic                  business_o
);
  localparam int unsigned SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned SCW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CCW = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned NW = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
  localparam logic [GEN_BITS-1:0] GEN_RETIRED = '1;

  // configuration
  logic                 pipe_q;
  logic [31:0]          ii_q;
  logic [3:0]           chans_q;
  logic [4:0]           slots_q;
  logic [SCW-1:0]       eff_slots;
  logic [CCW-1:0]       eff_chans;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_q <= 1'b0;
      ii_q <= '0;
      chans_q <= 4'd1;
      slots_q <= 5'd16;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PIPE: pipe_q <= cfg_data_i[0];
        REG_II: ii_q <= cfg_data_i;
        REG_CHANS: chans_q <= cfg_data_i[3:0];
        REG_SLOTS: slots_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (chans_q == 4'd0) eff_chans = CCW'(1);
    else if (32'(chans_q) > MAX_CHANNELS) eff_chans = CCW'(MAX_CHANNELS);
    else eff_chans = CCW'(chans_q);
    if (slots_q == 5'd0) eff_slots = SCW'(1);
    else if (32'(slots_q) > MAX_SLOTS) eff_slots = SCW'(MAX_SLOTS);
    else eff_slots = SCW'(slots_q);
  end

  // state
  logic [TIME_BITS-1:0]  issue_at_q, last_start_q, last_arrival_q;
  logic [TIME_BITS-1:0]  chan_free_q [MAX_CHANNELS];
  logic [MAX_SLOTS-1:0]  active_q, cancelled_q;
  logic [GEN_BITS-1:0]   gen_q [MAX_SLOTS];
  logic [OWNER_BITS-1:0] owner_q [MAX_SLOTS];
  logic [TIME_BITS-1:0]  sstart_q [MAX_SLOTS];
  logic [TIME_BITS-1:0]  sfinish_q [MAX_SLOTS];

  // latched command
  logic [1:0]            cmd_q;
  logic [TIME_BITS-1:0]  now_q, earl_q, dur_q, at_q;
  logic [OWNER_BITS-1:0] own_q;
  logic [3:0]            tslot_q;
  logic [GEN_BITS-1:0]   tgen_q;

  // scan
  logic [SCW-1:0]        si_q;
  logic [CCW-1:0]        ci_q;
  logic                  sfound_q;
  logic [SW-1:0]         slot_q;
  logic [CW-1:0]         ch_q;
  logic [TIME_BITS-1:0]  chmin_q;
  logic [TIME_BITS-1:0]  start_q;
  logic [TIME_BITS:0]    fin_q;
  logic [NW-1:0]         nxt_q;

  assign is_reserve_o = (command_i == CMD_RESERVE);
  assign stat_o.slot_done = sfound_q || (si_q >= eff_slots) ||
                            (!active_q[si_q[SW-1:0]] && gen_q[si_q[SW-1:0]] != GEN_RETIRED);
  assign stat_o.chan_done = (ci_q >= eff_chans);

  logic [TIME_BITS-1:0] calc_start;
  always_comb begin
    calc_start = earl_q;
    if (last_start_q > calc_start) calc_start = last_start_q;
    if (chmin_q > calc_start) calc_start = chmin_q;
    if (pipe_q && issue_at_q > calc_start) calc_start = issue_at_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i;
      now_q <= now_time_i;
      earl_q <= earliest_i;
      dur_q <= duration_i;
      at_q <= at_time_i;
      own_q <= owner_id_i;
      tslot_q <= ticket_slot_i;
      tgen_q <= ticket_generation_i;
    end
    if (cmd_i.calc) begin
      start_q <= calc_start;
      fin_q <= {1'b0, calc_start} + {1'b0, dur_q};
      nxt_q <= NW'(calc_start) + (pipe_q ? NW'(ii_q) : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      si_q <= '0;
      ci_q <= '0;
      sfound_q <= 1'b0;
      slot_q <= '0;
      ch_q <= '0;
      chmin_q <= '0;
    end else if (cmd_i.load) begin
      si_q <= '0;
      ci_q <= CCW'(1);
      sfound_q <= 1'b0;
      ch_q <= '0;
      chmin_q <= chan_free_q[0];
    end else if (cmd_i.scan_slot) begin
      if (si_q < eff_slots && !active_q[si_q[SW-1:0]] &&
          gen_q[si_q[SW-1:0]] != GEN_RETIRED) begin
        sfound_q <= 1'b1;
        slot_q <= si_q[SW-1:0];
      end else if (si_q < eff_slots) begin
        si_q <= si_q + SCW'(1);
      end
    end else if (cmd_i.scan_chan && ci_q < eff_chans) begin
      if (chan_free_q[ci_q[CW-1:0]] < chmin_q) begin
        chmin_q <= chan_free_q[ci_q[CW-1:0]];
        ch_q <= ci_q[CW-1:0];
      end
      ci_q <= ci_q + CCW'(1);
    end
  end

  // decision at commit
  logic [SW-1:0] ts;
  logic          tvalid, ticket_ok;
  logic [2:0]    st;
  logic [1:0]    disp;
  logic          bus;
  logic          wr_res, wr_cancel, wr_done;
  logic [TIME_BITS:0] tmax;

  assign ts = tslot_q[SW-1:0];
  assign tmax = {1'b0, {TIME_BITS{1'b1}}};
  always_comb begin
    tvalid = (32'(tslot_q) < 32'(eff_slots)) && (32'(tslot_q) < MAX_SLOTS);
    ticket_ok = tvalid && tgen_q != '0 && tgen_q == gen_q[ts] && own_q == owner_q[ts];
    st = ST_OK;
    disp = DISP_SETTLED;
    bus = 1'b0;
    wr_res = 1'b0;
    wr_cancel = 1'b0;
    wr_done = 1'b0;
    case (cmd_q)
      CMD_RESERVE: begin
        if (earl_q < now_q || now_q < last_arrival_q) st = ST_REGRESS;
        else if (!sfound_q) st = ST_FULL;
        else if (fin_q > tmax || nxt_q > NW'(tmax)) st = ST_OVERFLOW;
        else wr_res = 1'b1;
      end
      CMD_CANCEL: begin
        if (!ticket_ok) st = ST_STALE;
        else if (!active_q[ts]) disp = DISP_SETTLED;
        else if (cancelled_q[ts]) disp = DISP_CANCELLED;
        else begin
          wr_cancel = 1'b1;
          disp = (now_q >= sstart_q[ts]) ? DISP_DEFERRED : DISP_RETAINED;
        end
      end
      CMD_COMPLETE: begin
        if (at_q != now_q) st = ST_BAD_ARG;
        else if (!ticket_ok) st = ST_STALE;
        else if (!active_q[ts]) bus = 1'b0;
        else if (at_q < sfinish_q[ts]) st = ST_NOT_READY;
        else begin
          bus = !cancelled_q[ts];
          wr_done = 1'b1;
        end
      end
      default: st = ST_BAD_ARG;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_at_q <= '0;
      last_start_q <= '0;
      last_arrival_q <= '0;
      active_q <= '0;
      cancelled_q <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) chan_free_q[i] <= '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        gen_q[i] <= '0;
        owner_q[i] <= '0;
        sstart_q[i] <= '0;
        sfinish_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      if (wr_res) begin
        active_q[slot_q] <= 1'b1;
        cancelled_q[slot_q] <= 1'b0;
        gen_q[slot_q] <= gen_q[slot_q] + GEN_BITS'(1);
        owner_q[slot_q] <= own_q;
        sstart_q[slot_q] <= start_q;
        sfinish_q[slot_q] <= fin_q[TIME_BITS-1:0];
        chan_free_q[ch_q] <= fin_q[TIME_BITS-1:0];
        issue_at_q <= nxt_q[TIME_BITS-1:0];
        last_start_q <= start_q;
        last_arrival_q <= now_q;
      end
      if (wr_cancel) cancelled_q[ts] <= 1'b1;
      if (wr_done) active_q[ts] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.commit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_o <= st;
      start_time_o <= wr_res ? start_q : '0;
      finish_time_o <= wr_res ? fin_q[TIME_BITS-1:0] : '0;
      wait_time_o <= wr_res ? start_q - earl_q : '0;
      granted_slot_o <= wr_res ? 4'(slot_q) : '0;
      granted_channel_o <= wr_res ? 3'(ch_q) : '0;
      granted_generation_o <= wr_res ? gen_q[slot_q] + GEN_BITS'(1) : '0;
      disposition_o <= (cmd_q == CMD_CANCEL && st == ST_OK) ? disp : DISP_SETTLED;
      business_o <= (cmd_q == CMD_COMPLETE && st == ST_OK) ? bus : 1'b0;
    end
  end

  logic [3:0] phase;
  assign phase = {cmd_i.scan_slot, cmd_i.scan_chan, cmd_i.calc, cmd_i.commit};

  `RRS_ASSERT_NEXT(a_done_after_commit, clk_i, rst_ni, cmd_i.commit, done_o)
  `RRS_ASSERT(a_one_phase, clk_i, rst_ni, $onehot0(phase))
  `RRS_ASSERT_NEXT(a_grant_active, clk_i, rst_ni, cmd_i.commit && wr_res, active_q[slot_q])
endmodule

FILE: sv/resource_reservation_scheduler.sv
// Top level of the resource reservation scheduler.
// Usage:
//   Drive command_i and its fields with start high; the command is taken at the
//   edge where start is high and busy is low. Configuration writes use cfg_we_i,
//   cfg_index_i and cfg_data_i and land at the next edge; write only while idle.
//   One result per command appears on the result ports for one cycle with
//   done_o high. The receiver cannot stall.
// Command flow:
//   Cancel, complete and unknown commands skip the scans and go from the
//   transfer straight to commit and result. A reserve scans the slots one per
//   cycle up to the first free one, or through all of them when none is free,
//   then the channels, one per cycle, then computes, commits and presents the
//   result. The sequential slot and channel scans set how long a reserve takes.
//   busy falls at the edge that takes the result, and no new command is taken
//   while busy is high.
// Reset:
//   All slot, channel and time state clears; registers return to
//   one channel, sixteen slots, pipeline mode off.
`include "resource_reservation_scheduler_defines.svh"
module resource_reservation_scheduler import rrs_pkg::*; #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [31:0]           cfg_data_i,
  input  logic [1:0]            command_i,
  input  logic [TIME_BITS-1:0]  now_time_i,
  input  logic [TIME_BITS-1:0]  earliest_i,
  input  logic [TIME_BITS-1:0]  duration_i,
  input  logic [OWNER_BITS-1:0] owner_id_i,
  input  logic [3:0]            ticket_slot_i,
  input  logic [GEN_BITS-1:0]   ticket_generation_i,
  input  logic [TIME_BITS-1:0]  at_time_i,
  output logic                  done_o,
  output logic [2:0]            status_o,
  output logic [TIME_BITS-1:0]  start_time_o,
  output logic [TIME_BITS-1:0]  finish_time_o,
  output logic [TIME_BITS-1:0]  wait_time_o,
  output logic [3:0]            granted_slot_o,
  output logic [2:0]            granted_channel_o,
  output logic [GEN_BITS-1:0]   granted_generation_o,
  output logic [1:0]            disposition_o,
  output logic                  business_o
);
  rrs_cmd_t  cmd;
  rrs_stat_t stat;
  logic      is_reserve;

  rrs_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .is_reserve_i(is_reserve), .stat_i(stat),
    .cmd_o(cmd), .busy
  );

  rrs_datapath #(
    .TIME_BITS(TIME_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .is_reserve_o(is_reserve),
    .cfg_we_i, .cfg_index_i, .cfg_data_i, .command_i, .now_time_i, .earliest_i,
    .duration_i, .owner_id_i, .ticket_slot_i, .ticket_generation_i, .at_time_i,
    .done_o, .status_o, .start_time_o, .finish_time_o, .wait_time_o,
    .granted_slot_o, .granted_channel_o, .granted_generation_o, .disposition_o,
    .business_o
  );

  `RRS_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
  `RRS_ASSERT(a_done_ok, clk_i, rst_ni, !done_o || busy)
  `RRS_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, done_o, !busy)
endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the resource reservation scheduler.
`timescale 1ns / 1ps
module tb_top;
  import rrs_pkg::*;

  localparam logic [47:0] TIME_MAX = {48{1'b1}};
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  typedef struct {
    logic [1:0]  cmd;
    logic [47:0] now;
    logic [47:0] earl;
    logic [47:0] dur;
    logic [31:0] owner;
    logic [3:0]  slot;
    logic [31:0] gen;
    logic [47:0] at;
    bit          from_book;
    bit          ripe;
    int unsigned pick;
    int unsigned spoil;
  } order_t;

  typedef struct {
    logic [2:0]  status;
    logic [47:0] start;
    logic [47:0] finish;
    logic [47:0] wait_t;
    logic [3:0]  gslot;
    logic [2:0]  gchan;
    logic [31:0] ggen;
    logic [1:0]  disp;
    logic        biz;
  } grant_t;

  typedef struct {
    logic [3:0]  slot;
    logic [31:0] gen;
    logic [31:0] owner;
    logic [47:0] finish;
  } ticket_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = REG_PIPE;
  logic [31:0] cfg_data_i = '0;
  logic [1:0]  command_i = CMD_RESERVE;
  logic [47:0] now_time_i = '0;
  logic [47:0] earliest_i = '0;
  logic [47:0] duration_i = '0;
  logic [31:0] owner_id_i = '0;
  logic [3:0]  ticket_slot_i = '0;
  logic [31:0] ticket_generation_i = '0;
  logic [47:0] at_time_i = '0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [47:0] start_time_o;
  logic [47:0] finish_time_o;
  logic [47:0] wait_time_o;
  logic [3:0]  granted_slot_o;
  logic [2:0]  granted_channel_o;
  logic [31:0] granted_generation_o;
  logic [1:0]  disposition_o;
  logic        business_o;

  resource_reservation_scheduler DUT (.*);

  always #5 clk_i = ~clk_i;

  // scheduler shadow state
  logic        pipe_cfg;
  logic [31:0] ii_cfg;
  logic [3:0]  chans_cfg;
  logic [4:0]  slots_cfg;
  logic [47:0] issue_at, last_start, last_arrival;
  logic [47:0] chan_free[8];
  logic        s_active[16], s_cancelled[16];
  logic [31:0] s_gen[16], s_owner[16];
  logic [47:0] s_start[16], s_finish[16];

  order_t  pending[$];
  grant_t  expected_grants[$];
  ticket_t ticket_book[$];
  bit      taken = 0;
  bit      failed = 0;
  int unsigned burst_left = 0, gap_left = 0, quiet = 0;

  function automatic bit ticket_valid(logic [3:0] sl, logic [31:0] g, logic [31:0] ow,
                                      int unsigned ns);
    if (sl >= ns) return 0;
    if (g == 0 || g != s_gen[sl]) return 0;
    return ow == s_owner[sl];
  endfunction

  function automatic grant_t schedule(order_t o);
    grant_t r;
    int unsigned ns, nc, sl, ch;
    logic [47:0] st;
    logic [48:0] fin, nxt;
    ticket_t tk;
    r = '{default: '0};
    ns = (slots_cfg < 1) ? 1 : (slots_cfg > 16) ? 16 : slots_cfg;
    nc = (chans_cfg < 1) ? 1 : (chans_cfg > 8) ? 8 : chans_cfg;
    case (o.cmd)
      CMD_RESERVE: begin
        if (o.earl < o.now || o.now < last_arrival) begin
          r.status = ST_REGRESS;
          return r;
        end
        sl = ns;
        for (int i = ns - 1; i >= 0; i--)
          if (!s_active[i] && s_gen[i] != 32'hFFFF_FFFF) sl = i;
        if (sl == ns) begin
          r.status = ST_FULL;
          return r;
        end
        ch = 0;
        for (int i = 1; i < nc; i++)
          if (chan_free[i] < chan_free[ch]) ch = i;
        st = o.earl;
        if (last_start > st) st = last_start;
        if (chan_free[ch] > st) st = chan_free[ch];
        if (pipe_cfg && issue_at > st) st = issue_at;
        fin = {1'b0, st} + {1'b0, o.dur};
        nxt = {1'b0, st} + (pipe_cfg ? {17'd0, ii_cfg} : 49'd0);
        if (fin[48] || nxt[48]) begin
          r.status = ST_OVERFLOW;
          return r;
        end
        s_active[sl] = 1'b1;
        s_cancelled[sl] = 1'b0;
        s_gen[sl] = s_gen[sl] + 32'd1;
        s_owner[sl] = o.owner;
        s_start[sl] = st;
        s_finish[sl] = fin[47:0];
        chan_free[ch] = fin[47:0];
        issue_at = nxt[47:0];
        last_start = st;
        last_arrival = o.now;
        r.start = st;
        r.finish = fin[47:0];
        r.wait_t = st - o.earl;
        r.gslot = 4'(sl);
        r.gchan = 3'(ch);
        r.ggen = s_gen[sl];
        tk = '{slot: 4'(sl), gen: s_gen[sl], owner: o.owner, finish: fin[47:0]};
        ticket_book.insert(ticket_book.size(), tk);
        if (ticket_book.size() > 24) void'(ticket_book.pop_front());
      end
      CMD_CANCEL: begin
        if (!ticket_valid(o.slot, o.gen, o.owner, ns)) r.status = ST_STALE;
        else if (!s_active[o.slot]) r.disp = DISP_SETTLED;
        else if (s_cancelled[o.slot]) r.disp = DISP_CANCELLED;
        else begin
          s_cancelled[o.slot] = 1'b1;
          r.disp = (o.now >= s_start[o.slot]) ? DISP_DEFERRED : DISP_RETAINED;
        end
      end
      CMD_COMPLETE: begin
        if (o.at != o.now) r.status = ST_BAD_ARG;
        else if (!ticket_valid(o.slot, o.gen, o.owner, ns)) r.status = ST_STALE;
        else if (!s_active[o.slot]) r.biz = 1'b0;
        else if (o.at < s_finish[o.slot]) r.status = ST_NOT_READY;
        else begin
          r.biz = !s_cancelled[o.slot];
          s_active[o.slot] = 1'b0;
        end
      end
      default: r.status = ST_BAD_ARG;
    endcase
    return r;
  endfunction

  // driver
  always @(negedge clk_i) begin
    order_t o;
    ticket_t t;
    if (!start || taken) begin
      taken = 0;
      if (gap_left > 0 || pending.size() == 0 || !rst_ni) begin
        if (gap_left > 0) gap_left--;
        start <= 1'b0;
      end else begin
        o = pending.pop_front();
        if (o.from_book && ticket_book.size() > 0) begin
          t = ticket_book[o.pick % ticket_book.size()];
          o.slot = t.slot;
          o.gen = t.gen;
          o.owner = t.owner;
          if (o.ripe) begin
            o.now = t.finish + 48'($urandom_range(0, 3));
            o.at = o.now;
          end
          case (o.spoil)
            1: o.gen = o.gen ^ (32'd1 << $urandom_range(0, 31));
            2: o.owner = o.owner ^ (32'd1 << $urandom_range(0, 31));
            3: o.slot = o.slot + 4'd1;
            default: ;
          endcase
        end
        command_i <= o.cmd;
        now_time_i <= o.now;
        earliest_i <= o.earl;
        duration_i <= o.dur;
        owner_id_i <= o.owner;
        ticket_slot_i <= o.slot;
        ticket_generation_i <= o.gen;
        at_time_i <= o.at;
        start <= 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    order_t o;
    grant_t e;
    if (rst_ni) begin
      quiet++;
      if (start && !busy) begin
        o = '{cmd: command_i, now: now_time_i, earl: earliest_i, dur: duration_i,
              owner: owner_id_i, slot: ticket_slot_i, gen: ticket_generation_i,
              at: at_time_i, default: 0};
        expected_grants.insert(expected_grants.size(), schedule(o));
        taken = 1;
        quiet = 0;
      end
      if (done_o) begin
        quiet = 0;
        if (expected_grants.size() == 0) begin
          $error("result transfer with nothing expected");
          failed = 1;
        end else begin
          e = expected_grants.pop_front();
          if (status_o !== e.status) begin
            $error("status exp %0d got %0d", e.status, status_o); failed = 1;
          end
          if (start_time_o !== e.start) begin
            $error("start_time exp %0h got %0h", e.start, start_time_o); failed = 1;
          end
          if (finish_time_o !== e.finish) begin
            $error("finish_time exp %0h got %0h", e.finish, finish_time_o); failed = 1;
          end
          if (wait_time_o !== e.wait_t) begin
            $error("wait_time exp %0h got %0h", e.wait_t, wait_time_o); failed = 1;
          end
          if (granted_slot_o !== e.gslot) begin
            $error("granted_slot exp %0d got %0d", e.gslot, granted_slot_o); failed = 1;
          end
          if (granted_channel_o !== e.gchan) begin
            $error("granted_channel exp %0d got %0d", e.gchan, granted_channel_o);
            failed = 1;
          end
          if (granted_generation_o !== e.ggen) begin
            $error("granted_generation exp %0h got %0h", e.ggen, granted_generation_o);
            failed = 1;
          end
          if (disposition_o !== e.disp) begin
            $error("disposition exp %0d got %0d", e.disp, disposition_o); failed = 1;
          end
          if (business_o !== e.biz) begin
            $error("business exp %0d got %0d", e.biz, business_o); failed = 1;
          end
        end
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  logic [47:0] tnow = 48'd10;

  function automatic order_t blank(logic [1:0] c);
    order_t o;
    o = '{cmd: c, now: tnow, earl: tnow, default: 0};
    o.at = tnow;
    return o;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_PIPE:  pipe_cfg = val[0];
      REG_II:    ii_cfg = val;
      REG_CHANS: chans_cfg = val[3:0];
      default:   slots_cfg = val[4:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(logic pm, logic [31:0] ii, logic [31:0] ch, logic [31:0] sl);
    wait (pending.size() == 0 && !start && expected_grants.size() == 0);
    repeat (30) @(posedge clk_i);
    write_reg(REG_PIPE, {31'd0, pm});
    write_reg(REG_II, ii);
    write_reg(REG_CHANS, ch);
    write_reg(REG_SLOTS, sl);
  endtask

  task automatic add_random(int unsigned n);
    order_t o;
    int unsigned k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 45) begin
        o = blank(CMD_RESERVE);
        o.earl = tnow + 48'($urandom_range(0, 40));
        o.dur = 48'($urandom_range(0, 60));
        o.owner = $urandom();
        if ($urandom_range(0, 15) == 0) tnow += 48'($urandom_range(100, 2000));
        else tnow += 48'($urandom_range(0, 6));
      end else if (k < 85) begin
        o = blank((k < 60) ? CMD_CANCEL : CMD_COMPLETE);
        o.now = tnow + 48'($urandom_range(0, 30));
        o.at = o.now;
        o.from_book = 1;
        o.ripe = (o.cmd == CMD_COMPLETE) && $urandom_range(0, 2) != 0;
        o.pick = $urandom();
        o.spoil = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
      end else if (k < 90) begin
        // overflow: high earliest with a long service
        o = blank(CMD_RESERVE);
        o.earl = {1'b1, 47'(($urandom() << 16) ^ $urandom())};
        o.dur = TIME_MAX - 48'($urandom_range(0, 7));
        o.owner = $urandom();
      end else if (k < 95) begin
        // time regression with random now
        o = blank(CMD_RESERVE);
        o.now = {$urandom(), 16'(~$urandom())} | 48'd1;
        o.earl = '0;
        o.dur = {$urandom(), 16'($urandom())};
      end else begin
        o = blank(2'($urandom_range(1, 3)));
        o.now = {$urandom(), 16'($urandom())};
        o.at = ($urandom_range(0, 1)) ? o.now : {$urandom(), 16'($urandom())};
        o.owner = $urandom();
        o.slot = 4'($urandom());
        o.gen = $urandom();
      end
      pending.insert(pending.size(), o);
    end
  endtask

  initial begin
    order_t o;
    pipe_cfg = 1'b0; ii_cfg = '0; chans_cfg = 4'd1; slots_cfg = 5'd16;
    issue_at = '0; last_start = '0; last_arrival = '0;
    for (int i = 0; i < 8; i++) chan_free[i] = '0;
    for (int i = 0; i < 16; i++) begin
      s_active[i] = 1'b0; s_cancelled[i] = 1'b0; s_gen[i] = '0; s_owner[i] = '0;
      s_start[i] = '0; s_finish[i] = '0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: serial resource, small table
    configure(1'b0, 32'd0, 32'd1, 32'd2);
    o = blank(CMD_RESERVE); o.dur = 48'd5; o.owner = 32'hFFFF_FFFF;
    pending.insert(pending.size(), o);
    o = blank(CMD_RESERVE); o.earl = tnow + 48'd3; o.dur = '0; o.owner = 32'd7;
    pending.insert(pending.size(), o);
    o = blank(CMD_RESERVE); o.earl = tnow + 48'd1; o.dur = 48'd1;
    pending.insert(pending.size(), o);
    o = blank(CMD_CANCEL); o.from_book = 1; o.pick = 0; pending.insert(pending.size(), o);
    o = blank(CMD_CANCEL); o.from_book = 1; o.pick = 0; pending.insert(pending.size(), o);
    o = blank(CMD_CANCEL); o.from_book = 1; o.pick = 1; o.now = '0;
    pending.insert(pending.size(), o);
    o = blank(CMD_COMPLETE); o.from_book = 1; o.pick = 0;
    pending.insert(pending.size(), o);
    o = blank(CMD_COMPLETE); o.from_book = 1; o.pick = 0; o.ripe = 1;
    pending.insert(pending.size(), o);
    o = blank(CMD_COMPLETE); o.from_book = 1; o.pick = 0; o.ripe = 1;
    pending.insert(pending.size(), o);
    o = blank(CMD_CANCEL); o.from_book = 1; o.pick = 0; pending.insert(pending.size(), o);
    o = blank(CMD_COMPLETE); o.from_book = 1; o.pick = 1; o.at = tnow + 48'd1;
    pending.insert(pending.size(), o);
    o = blank(CMD_COMPLETE); o.from_book = 1; o.pick = 1; o.spoil = 1; o.ripe = 1;
    pending.insert(pending.size(), o);
    o = blank(CMD_CANCEL); o.from_book = 1; o.pick = 1; o.spoil = 2;
    pending.insert(pending.size(), o);
    o = blank(CMD_CANCEL); o.from_book = 1; o.pick = 1; o.spoil = 3;
    pending.insert(pending.size(), o);
    o = blank(CMD_CANCEL); o.slot = 4'hF; o.gen = '0; pending.insert(pending.size(), o);
    o = blank(2'd3); pending.insert(pending.size(), o);
    o = blank(CMD_RESERVE); o.earl = tnow - 48'd1; pending.insert(pending.size(), o);
    o = blank(CMD_RESERVE); o.earl = TIME_MAX; o.dur = TIME_MAX;
    pending.insert(pending.size(), o);
    add_random(60);

    configure(1'b1, 32'd3, 32'd8, 32'd4);
    add_random(90);
    configure(1'b1, 32'hFFFF_FFFF, 32'd3, 32'd1);
    add_random(50);
    configure(1'b0, 32'd0, 32'd0, 32'd0);
    add_random(50);
    configure(1'b1, 32'd0, 32'd15, 32'd31);
    add_random(60);
    configure(1'b0, 32'hA5A5_5A5A, 32'd8, 32'd16);
    add_random(140);
    // start at the top of the time range with no service
    o = blank(CMD_RESERVE); o.earl = TIME_MAX; o.dur = '0;
    pending.insert(pending.size(), o);

    wait (pending.size() == 0 && !start && expected_grants.size() == 0);
    repeat (40) @(posedge clk_i);
    if (!failed && expected_grants.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
